// ===== src/psd_pkg.sv =====
// Package for the point-to-segment distance block: item types, region codes
// and pipeline sizes. No dependencies; used by the top level and its checker.
`default_nettype none

package psd_pkg;

	// Region codes of a result item
	localparam logic [1:0] REGION_START    = 2'd0;
	localparam logic [1:0] REGION_END      = 2'd1;
	localparam logic [1:0] REGION_INTERIOR = 2'd2;

	// One quotient bit per divider stage, one root bit per square-root stage
	localparam int DIV_STEPS  = 17;
	localparam int SQRT_STEPS = 17;

	localparam logic [16:0] DIST_MAX = 17'd92682;

	typedef struct packed {
		logic signed [15:0] seg_start_x;
		logic signed [15:0] seg_start_y;
		logic signed [15:0] seg_end_x;
		logic signed [15:0] seg_end_y;
		logic signed [15:0] query_x;
		logic signed [15:0] query_y;
	} in_t;

	typedef struct packed {
		logic signed [15:0] nearest_x;
		logic signed [15:0] nearest_y;
		logic        [16:0] distance;
		logic        [1:0]  region;
	} out_t;

	// Sideband that rides along the divider stages
	typedef struct packed {
		in_t        pt;
		logic [1:0] region;
		logic       neg_x;
		logic       neg_y;
	} div_side_t;

	// Sideband that rides along the square-root stages
	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic [1:0]         region;
	} sqrt_side_t;

endpackage

`default_nettype wire

// ===== src/point_segment_distance.sv =====
// Top level of the point-to-segment distance pipeline.
// Depends on psd_pkg for item types, region codes and stage counts.
`default_nettype none

// Nearest point on segment A-B to query point C, with region code and the
// distance to it; coordinates in Q8.8, distance in unsigned Q9.8. The block is
// a fixed pipeline of 44 register stages: setup and products (5), a 17-stage
// restoring divider for the projected offsets, nearest-point and squaring
// stages (4), a 17-stage square-root unit, and the output register. It accepts
// one item per cycle while the output side does not stall. A stall at the
// output freezes the whole pipeline, so in_ready drops for exactly the cycles
// in which a finished result is not taken.
module point_segment_distance (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire psd_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output psd_pkg::out_t      out_data
);

	localparam int ND = psd_pkg::DIV_STEPS;
	localparam int NS = psd_pkg::SQRT_STEPS;

	logic en;

	// Per-stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic div_v_s [ND];
	logic sq_v_s [NS];

	// Advance everything when the output slot is free or being taken
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: differences
	psd_pkg::in_t       pt_s1;
	logic signed [16:0] ex_s1, ey_s1, wx_s1, wy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1 <= in_data;
			ex_s1 <= 17'(in_data.seg_end_x) - 17'(in_data.seg_start_x);
			ey_s1 <= 17'(in_data.seg_end_y) - 17'(in_data.seg_start_y);
			wx_s1 <= 17'(in_data.query_x) - 17'(in_data.seg_start_x);
			wy_s1 <= 17'(in_data.query_y) - 17'(in_data.seg_start_y);
		end
	end

	// Stage 2: four products
	psd_pkg::in_t       pt_s2;
	logic signed [16:0] ex_s2, ey_s2;
	logic signed [33:0] eex_s2, eey_s2, nwx_s2, nwy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s2  <= pt_s1;
			ex_s2  <= ex_s1;
			ey_s2  <= ey_s1;
			eex_s2 <= ex_s1 * ex_s1;
			eey_s2 <= ey_s1 * ey_s1;
			nwx_s2 <= wx_s1 * ex_s1;
			nwy_s2 <= wy_s1 * ey_s1;
		end
	end

	// Stage 3: dot product, squared length, region and magnitudes
	logic [33:0]        den_c;
	logic signed [34:0] num_c;
	logic [1:0]         region_c;

	assign den_c = eex_s2[33:0] + eey_s2[33:0];
	assign num_c = {nwx_s2[33], nwx_s2} + {nwy_s2[33], nwy_s2};

	always_comb begin
		if (den_c == '0 || num_c[34]) begin
			region_c = psd_pkg::REGION_START;
		end else if (num_c > $signed({1'b0, den_c})) begin
			region_c = psd_pkg::REGION_END;
		end else begin
			region_c = psd_pkg::REGION_INTERIOR;
		end
	end

	psd_pkg::in_t pt_s3;
	logic [33:0]  den_s3, num_s3;
	logic [16:0]  magx_s3, magy_s3;
	logic [1:0]   region_s3;
	logic         negx_s3, negy_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s3     <= pt_s2;
			den_s3    <= den_c;
			num_s3    <= num_c[33:0];
			region_s3 <= region_c;
			negx_s3   <= ex_s2[16];
			negy_s3   <= ey_s2[16];
			magx_s3   <= ex_s2[16] ? 17'(-ex_s2) : 17'(ex_s2);
			magy_s3   <= ey_s2[16] ? 17'(-ey_s2) : 17'(ey_s2);
		end
	end

	// Stage 4: num times offset magnitude, cut into two 17x17 halves
	psd_pkg::div_side_t side_s4;
	logic [33:0]        den_s4;
	logic [33:0]        plx_s4, phx_s4, ply_s4, phy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= '{pt: pt_s3, region: region_s3, neg_x: negx_s3, neg_y: negy_s3};
			den_s4  <= den_s3;
			plx_s4  <= num_s3[16:0] * magx_s3;
			phx_s4  <= num_s3[33:17] * magx_s3;
			ply_s4  <= num_s3[16:0] * magy_s3;
			phy_s4  <= num_s3[33:17] * magy_s3;
		end
	end

	// Stage 5: rounded dividends; top part seeds the divider remainder
	logic [50:0] dx_c, dy_c;

	assign dx_c = {phx_s4[33:0], 17'd0} + {17'd0, plx_s4} + {18'd0, den_s4[33:1]};
	assign dy_c = {phy_s4[33:0], 17'd0} + {17'd0, ply_s4} + {18'd0, den_s4[33:1]};

	psd_pkg::div_side_t side_s5;
	logic [33:0]        den_s5;
	logic [33:0]        remx_s5, remy_s5;
	logic [16:0]        lowx_s5, lowy_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			den_s5  <= den_s4;
			remx_s5 <= dx_c[50:17];
			remy_s5 <= dy_c[50:17];
			lowx_s5 <= dx_c[16:0];
			lowy_s5 <= dy_c[16:0];
		end
	end

	// Divider stages: one quotient bit per stage, x and y lanes side by side
	psd_pkg::div_side_t div_side_s [ND];
	logic [33:0]        div_den_s  [ND];
	logic [33:0]        div_rem_s  [ND][2];
	logic [16:0]        div_low_s  [ND][2];
	logic [16:0]        div_q_s    [ND][2];

	logic [33:0] div_rem_d [ND][2];
	logic [16:0] div_low_d [ND][2];
	logic [16:0] div_q_d   [ND][2];

	always_comb begin
		logic [33:0] rin;
		logic [16:0] lin;
		logic [16:0] qin;
		logic [33:0] dn;
		logic [34:0] t;
		logic        ge;
		for (int k = 0; k < ND; k++) begin
			for (int c = 0; c < 2; c++) begin
				if (k == 0) begin
					rin = (c == 0) ? remx_s5 : remy_s5;
					lin = (c == 0) ? lowx_s5 : lowy_s5;
					qin = '0;
					dn  = den_s5;
				end else begin
					rin = div_rem_s[k-1][c];
					lin = div_low_s[k-1][c];
					qin = div_q_s[k-1][c];
					dn  = div_den_s[k-1];
				end
				t  = {rin, lin[16]};
				ge = t >= {1'b0, dn};
				div_rem_d[k][c] = ge ? 34'(t - {1'b0, dn}) : t[33:0];
				div_low_d[k][c] = {lin[15:0], 1'b0};
				div_q_d[k][c]   = {qin[15:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ND; k++) begin
				div_side_s[k] <= (k == 0) ? side_s5 : div_side_s[k-1];
				div_den_s[k]  <= (k == 0) ? den_s5 : div_den_s[k-1];
				for (int c = 0; c < 2; c++) begin
					div_rem_s[k][c] <= div_rem_d[k][c];
					div_low_s[k][c] <= div_low_d[k][c];
					div_q_s[k][c]   <= div_q_d[k][c];
				end
			end
		end
	end

	// Stage 6: pick the nearest point; interior offsets saturate
	psd_pkg::div_side_t dlast;
	logic signed [17:0] sumx_c, sumy_c;
	logic signed [15:0] satx_c, saty_c, nx_c, ny_c;

	assign dlast  = div_side_s[ND-1];
	assign sumx_c = 18'(dlast.pt.seg_start_x) + (dlast.neg_x ?
		-$signed({1'b0, div_q_s[ND-1][0]}) : $signed({1'b0, div_q_s[ND-1][0]}));
	assign sumy_c = 18'(dlast.pt.seg_start_y) + (dlast.neg_y ?
		-$signed({1'b0, div_q_s[ND-1][1]}) : $signed({1'b0, div_q_s[ND-1][1]}));

	always_comb begin
		if (sumx_c > 18'sd32767) begin
			satx_c = 16'sh7fff;
		end else if (sumx_c < -18'sd32768) begin
			satx_c = 16'sh8000;
		end else begin
			satx_c = sumx_c[15:0];
		end
		if (sumy_c > 18'sd32767) begin
			saty_c = 16'sh7fff;
		end else if (sumy_c < -18'sd32768) begin
			saty_c = 16'sh8000;
		end else begin
			saty_c = sumy_c[15:0];
		end
		case (dlast.region)
			psd_pkg::REGION_END: begin
				nx_c = dlast.pt.seg_end_x;
				ny_c = dlast.pt.seg_end_y;
			end
			psd_pkg::REGION_INTERIOR: begin
				nx_c = satx_c;
				ny_c = saty_c;
			end
			default: begin
				nx_c = dlast.pt.seg_start_x;
				ny_c = dlast.pt.seg_start_y;
			end
		endcase
	end

	psd_pkg::sqrt_side_t side_s6;
	logic signed [15:0]  qx_s6, qy_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= '{nx: nx_c, ny: ny_c, region: dlast.region};
			qx_s6   <= dlast.pt.query_x;
			qy_s6   <= dlast.pt.query_y;
		end
	end

	// Stage 7: offsets from query to nearest point
	psd_pkg::sqrt_side_t side_s7;
	logic signed [16:0]  ddx_s7, ddy_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_s6;
			ddx_s7  <= 17'(qx_s6) - 17'(side_s6.nx);
			ddy_s7  <= 17'(qy_s6) - 17'(side_s6.ny);
		end
	end

	// Stage 8: squares
	psd_pkg::sqrt_side_t side_s8;
	logic signed [33:0]  sqx_s8, sqy_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8 <= side_s7;
			sqx_s8  <= ddx_s7 * ddx_s7;
			sqy_s8  <= ddy_s7 * ddy_s7;
		end
	end

	// Stage 9: squared distance
	psd_pkg::sqrt_side_t side_s9;
	logic [33:0]         ssum_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s9 <= side_s8;
			ssum_s9 <= sqx_s8[33:0] + sqy_s8[33:0];
		end
	end

	// Square-root stages: one root bit per stage from the top bit pair down
	psd_pkg::sqrt_side_t sq_side_s [NS];
	logic [18:0]         sq_rem_s  [NS];
	logic [16:0]         sq_root_s [NS];
	logic [33:0]         sq_rad_s  [NS];

	logic [18:0] sq_rem_d  [NS];
	logic [16:0] sq_root_d [NS];
	logic [33:0] sq_rad_d  [NS];

	always_comb begin
		logic [18:0] rin;
		logic [16:0] oin;
		logic [33:0] ain;
		logic [20:0] r;
		logic [20:0] trial;
		logic        ge;
		for (int k = 0; k < NS; k++) begin
			if (k == 0) begin
				rin = '0;
				oin = '0;
				ain = ssum_s9;
			end else begin
				rin = sq_rem_s[k-1];
				oin = sq_root_s[k-1];
				ain = sq_rad_s[k-1];
			end
			r     = {rin, ain[33:32]};
			trial = {2'b00, oin, 2'b01};
			ge    = r >= trial;
			sq_rem_d[k]  = ge ? 19'(r - trial) : r[18:0];
			sq_root_d[k] = {oin[15:0], ge};
			sq_rad_d[k]  = {ain[31:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NS; k++) begin
				sq_side_s[k] <= (k == 0) ? side_s9 : sq_side_s[k-1];
				sq_rem_s[k]  <= sq_rem_d[k];
				sq_root_s[k] <= sq_root_d[k];
				sq_rad_s[k]  <= sq_rad_d[k];
			end
		end
	end

	// Output register: round the root up when the remainder exceeds it
	always_ff @(posedge clk) begin
		if (en) begin
			out_data.nearest_x <= sq_side_s[NS-1].nx;
			out_data.nearest_y <= sq_side_s[NS-1].ny;
			out_data.region    <= sq_side_s[NS-1].region;
			out_data.distance  <= sq_root_s[NS-1] +
				17'(sq_rem_s[NS-1] > {2'b00, sq_root_s[NS-1]});
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			out_valid <= 1'b0;
			for (int k = 0; k < ND; k++) begin
				div_v_s[k] <= 1'b0;
			end
			for (int k = 0; k < NS; k++) begin
				sq_v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			for (int k = 0; k < ND; k++) begin
				div_v_s[k] <= (k == 0) ? v_s5 : div_v_s[k-1];
			end
			v_s6 <= div_v_s[ND-1];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			for (int k = 0; k < NS; k++) begin
				sq_v_s[k] <= (k == 0) ? v_s9 : sq_v_s[k-1];
			end
			out_valid <= sq_v_s[NS-1];
		end
	end

endmodule

`default_nettype wire

// ===== src/psd_checker.sv =====
// Port-level checker for the point-to-segment distance block, and its bind.
// Depends on psd_pkg for the result type and region codes.
`default_nettype none

module psd_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire psd_pkg::out_t out_data
);

	// Hold a result that is not taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// Accept input exactly when the output slot can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output slot");

	// Region code stays in its set
	a_region: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.region == psd_pkg::REGION_START ||
			out_data.region == psd_pkg::REGION_END ||
			out_data.region == psd_pkg::REGION_INTERIOR))
		else $error("bad region code");

	// Distance stays within the reachable range
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.distance <= psd_pkg::DIST_MAX)
		else $error("distance out of range");

endmodule

bind point_segment_distance psd_checker u_psd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ===== tb/point_segment_distance_tb.sv =====
// Testbench for the point-to-segment distance pipeline: directed table plus random queries,
// each checked against a typed-in or predicted result. Depends on psd_pkg and the top level.
`timescale 1ns / 1ps

module point_segment_distance_tb;

	localparam int LATENCY = 44;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	psd_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_ready;
	psd_pkg::out_t out_data;

	int            sender_idle_pct;
	int            receiver_stall_pct;
	int            error_count;
	int            result_count;
	int            item_count;
	psd_pkg::out_t nearest_queue[$];

	typedef struct {
		psd_pkg::in_t  pt;
		bit            known;
		psd_pkg::out_t res;
	} row_t;

	row_t rows[$];

	point_segment_distance u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Bound the run well past the slowest correct case
	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Round-to-nearest square root of a nonnegative integer
	function automatic longint unsigned root_round(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		// v now holds the remainder s - r*r
		if (v > r) r += 1;
		return r;
	endfunction

	function automatic longint quot_round(longint n, longint d);
		longint m;
		longint q;
		m = (n < 0) ? -n : n;
		q = (m + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Predict nearest point, region and distance for one query
	function automatic psd_pkg::out_t nearest_point(psd_pkg::in_t p);
		longint ax, ay, bx, by, cx, cy, ex, ey, den, num, px, py, dx, dy;
		psd_pkg::out_t o;
		ax = p.seg_start_x;
		ay = p.seg_start_y;
		bx = p.seg_end_x;
		by = p.seg_end_y;
		cx = p.query_x;
		cy = p.query_y;
		ex = bx - ax;
		ey = by - ay;
		den = ex * ex + ey * ey;
		num = (cx - ax) * ex + (cy - ay) * ey;
		if (den == 0 || num < 0) begin
			px = ax;
			py = ay;
			o.region = psd_pkg::REGION_START;
		end else if (num > den) begin
			px = bx;
			py = by;
			o.region = psd_pkg::REGION_END;
		end else begin
			px = clip16(ax + quot_round(num * ex, den));
			py = clip16(ay + quot_round(num * ey, den));
			o.region = psd_pkg::REGION_INTERIOR;
		end
		dx = cx - px;
		dy = cy - py;
		o.nearest_x = px[15:0];
		o.nearest_y = py[15:0];
		o.distance = 17'(root_round(longint'(dx * dx + dy * dy)));
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch on %s at result %0d: got %0d, want %0d",
			$realtime, what, result_count, got, want);
		error_count++;
	endtask

	// Random coordinate, biased toward extremes and small values
	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'h8000 + 16'($urandom_range(0, 3));
			1: return 16'h7FFF - 16'($urandom_range(0, 3));
			2: return 16'($signed($urandom_range(0, 1024)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic psd_pkg::in_t rand_query();
		psd_pkg::in_t p;
		p.seg_start_x = rand_coord();
		p.seg_start_y = rand_coord();
		// Sometimes a degenerate segment
		if ($urandom_range(0, 15) == 0) begin
			p.seg_end_x = p.seg_start_x;
			p.seg_end_y = p.seg_start_y;
		end else begin
			p.seg_end_x = rand_coord();
			p.seg_end_y = rand_coord();
		end
		p.query_x = rand_coord();
		p.query_y = rand_coord();
		return p;
	endfunction

	// Drive one item; hold valid and payload until accepted
	task automatic send_item(psd_pkg::in_t p, bit known, psd_pkg::out_t res);
		while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		nearest_queue.push_back(known ? res : nearest_point(p));
		item_count++;
	endtask

	// Randomize the receiver stall each cycle; hold it low in reset
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		psd_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (nearest_queue.size() == 0) begin
				$display("%0t: result with no expectation waiting", $realtime);
				error_count++;
			end else begin
				want = nearest_queue.pop_front();
				if (out_data.nearest_x !== want.nearest_x)
					report_mismatch("nearest_x", out_data.nearest_x, want.nearest_x);
				if (out_data.nearest_y !== want.nearest_y)
					report_mismatch("nearest_y", out_data.nearest_y, want.nearest_y);
				if (out_data.distance !== want.distance)
					report_mismatch("distance", out_data.distance, want.distance);
				if (out_data.region !== want.region)
					report_mismatch("region", out_data.region, want.region);
			end
			result_count++;
		end
	end

	function automatic psd_pkg::in_t mk(int ax, int ay, int bx, int by, int cx, int cy);
		psd_pkg::in_t p;
		p.seg_start_x = 16'(ax);
		p.seg_start_y = 16'(ay);
		p.seg_end_x   = 16'(bx);
		p.seg_end_y   = 16'(by);
		p.query_x     = 16'(cx);
		p.query_y     = 16'(cy);
		return p;
	endfunction

	function automatic psd_pkg::out_t res(int nx, int ny, int d, logic [1:0] r);
		psd_pkg::out_t o;
		o.nearest_x = 16'(nx);
		o.nearest_y = 16'(ny);
		o.distance  = 17'(d);
		o.region    = r;
		return o;
	endfunction

	task automatic add_row(psd_pkg::in_t p, bit known, psd_pkg::out_t r);
		row_t w;
		w.pt = p;
		w.known = known;
		w.res = r;
		rows.push_back(w);
	endtask

	task automatic drain();
		while (nearest_queue.size() != 0) @(posedge clk);
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		error_count = 0;
		result_count = 0;
		item_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: obvious rows typed in, the rest predicted
		add_row(mk(0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, psd_pkg::REGION_START));
		add_row(mk(256, 256, 256, 256, 256 + 768, 256 + 1024), 1,
			res(256, 256, 1280, psd_pkg::REGION_START));
		add_row(mk(0, 0, 256, 0, -256, 0), 1, res(0, 0, 256, psd_pkg::REGION_START));
		add_row(mk(0, 0, 256, 0, 512, 0), 1, res(256, 0, 256, psd_pkg::REGION_END));
		add_row(mk(0, 0, 256, 0, 128, 300), 1,
			res(128, 0, 300, psd_pkg::REGION_INTERIOR));
		add_row(mk(0, 0, 256, 0, 0, 100), 1, res(0, 0, 100, psd_pkg::REGION_INTERIOR));
		add_row(mk(0, 0, 256, 0, 256, 100), 1,
			res(256, 0, 100, psd_pkg::REGION_INTERIOR));
		add_row(mk(-32768, -32768, -32768, -32768, 32767, 32767), 1,
			res(-32768, -32768, 92680, psd_pkg::REGION_START));
		add_row(mk(-32768, -32768, 32767, 32767, 32767, -32768), 0, '0);
		add_row(mk(-32768, 32767, 32767, -32768, 0, 0), 0, '0);
		add_row(mk(32767, 32767, -32768, -32768, -32768, -32768), 1,
			res(-32768, -32768, 0, psd_pkg::REGION_INTERIOR));
		add_row(mk(-32768, 0, 32767, 0, 32767, 32767), 0, '0);
		add_row(mk(0, -32768, 0, 32767, -32768, 100), 0, '0);
		add_row(mk(1, 0, 0, 1, 1, 1), 0, '0);
		add_row(mk(0, 0, 3, 0, 1, 5), 0, '0);
		add_row(mk(0, 0, 3, 1, 2, -7), 0, '0);
		add_row(mk(-5, 7, 100, -200, 3000, 3000), 0, '0);
		add_row(mk(100, 100, 101, 101, -32768, 32767), 0, '0);
		add_row(mk(-1, -1, -1, -1, 32767, -32768), 0, '0);
		foreach (rows[i]) send_item(rows[i].pt, rows[i].known, rows[i].res);

		// Random phases over the idling mixes
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
				default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
			endcase
			repeat (430) send_item(rand_query(), 0, '0);
			// Hold off until the pipeline is empty
			in_valid <= 1'b0;
			@(posedge clk);
			drain();
		end

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		$display("Ran %0d segment queries (directed and random) under four idle/stall mixes;",
			item_count);
		$display("checked %0d results for nearest point, region and distance.", result_count);
		if (error_count == 0 && nearest_queue.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
